FILE: sv/ght_pkg.sv
package ght_pkg;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_BAD  = 2'd1,
    STATUS_FULL = 2'd2,
    STATUS_RSVD = 2'd3
  } status_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;     // latch the command word, issue slot reads
    logic eval;        // decide with slot data, issue dense reads
    logic commit;      // write memories and counters
    logic move;        // write the moved entry on delete
    logic respond;     // drive the result strobe
  } ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_move;   // delete must relocate the last dense entry
  } sts_t;

endpackage

FILE: sv/ght_ram.sv
module ght_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: sv/ght_ctrl.sv
module ght_ctrl
  import ght_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output ctl_t ctl_o,
  output logic busy_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StEval = 3'd2;
  localparam logic [2:0] StComm = 3'd3;
  localparam logic [2:0] StMove = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          ctl_o.capture = 1'b1;
          state_d = StRead;
        end
      end
      StRead: begin
        state_d = StEval;
      end
      StEval: begin
        ctl_o.eval = 1'b1;
        state_d = StComm;
      end
      StComm: begin
        ctl_o.commit = 1'b1;
        if (sts_i.need_move) begin
          state_d = StMove;
        end else begin
          ctl_o.respond = 1'b1;
          state_d = StIdle;
        end
      end
      StMove: begin
        ctl_o.move    = 1'b1;
        ctl_o.respond = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != StIdle);

  a_move_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.move |-> $past(ctl_o.commit))
    else $error("move without commit");
  a_one_respond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.respond |=> !ctl_o.respond)
    else $error("back to back respond");
  a_capture_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.capture |=> busy_o)
    else $error("capture did not go busy");

endmodule

FILE: sv/ght_dp.sv
module ght_dp
  import ght_pkg::*;
#(
  parameter int SlotCount = 64,
  parameter int GenBits   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ctl_t                         ctl_i,
  output sts_t                         sts_o,
  input  logic [1:0]                   mode_i,
  input  logic [$clog2(SlotCount)-1:0] handle_index_i,
  input  logic [GenBits-1:0]           handle_generation_i,
  input  logic [31:0]                  pos_x_i,
  input  logic [31:0]                  pos_y_i,
  input  logic [31:0]                  pos_z_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [$clog2(SlotCount)-1:0] result_index_o,
  output logic [GenBits-1:0]           result_generation_o,
  output logic [$clog2(SlotCount)-1:0] dense_position_o,
  output logic [31:0]                  out_x_o,
  output logic [31:0]                  out_y_o,
  output logic [31:0]                  out_z_o
);

  localparam int IW = $clog2(SlotCount);
  localparam int CW = IW + 1;
  localparam int PW = 96;
  localparam logic [CW-1:0] Full = CW'(SlotCount);

  // Command word.
  logic [1:0]         mode_q;
  logic [IW-1:0]      idx_q;
  logic [GenBits-1:0] gen_q;
  logic [PW-1:0]      pos_q;

  // Control state.
  logic [SlotCount-1:0] active_q;
  logic [CW-1:0] opened_q, fcount_q, dcount_q;
  logic [IW-1:0] fhead_q;

  // Decision registers.
  logic          ok_q, got_q, reuse_q, move_q;
  logic [IW-1:0] slot_q, hole_q, last_q;
  logic [GenBits-1:0] newgen_q;
  logic [1:0]    st_q;

  // Memory ports.
  logic [GenBits-1:0] gen_rd;
  logic [IW-1:0]      sdi_rd, fifo_rd, owner_rd;
  logic [PW-1:0]      pay_rd;
  logic               gen_we, sdi_we, fifo_we, owner_we, pay_we;
  logic [IW-1:0]      gen_wa, sdi_wa, fifo_wa, owner_wa, pay_wa, pay_ra, owner_ra;
  logic [GenBits-1:0] gen_wd;
  logic [IW-1:0]      sdi_wd, owner_wd;
  logic [PW-1:0]      pay_wd;

  ght_ram #(.Width(GenBits), .Depth(SlotCount)) u_gen (
    .clk_i, .we_i(gen_we), .waddr_i(gen_wa), .wdata_i(gen_wd),
    .raddr_i(ctl_i.capture ? handle_index_i : fifo_rd), .rdata_o(gen_rd));
  ght_ram #(.Width(IW), .Depth(SlotCount)) u_sdi (
    .clk_i, .we_i(sdi_we), .waddr_i(sdi_wa), .wdata_i(sdi_wd),
    .raddr_i(handle_index_i), .rdata_o(sdi_rd));
  ght_ram #(.Width(IW), .Depth(SlotCount)) u_fifo (
    .clk_i, .we_i(fifo_we), .waddr_i(fifo_wa), .wdata_i(idx_q),
    .raddr_i(fhead_q), .rdata_o(fifo_rd));
  ght_ram #(.Width(IW), .Depth(SlotCount)) u_owner (
    .clk_i, .we_i(owner_we), .waddr_i(owner_wa), .wdata_i(owner_wd),
    .raddr_i(owner_ra), .rdata_o(owner_rd));
  ght_ram #(.Width(PW), .Depth(SlotCount)) u_pay (
    .clk_i, .we_i(pay_we), .waddr_i(pay_wa), .wdata_i(pay_wd),
    .raddr_i(pay_ra), .rdata_o(pay_rd));

  // Capture cycle reads gen/sdi at handle, fifo at head. Read cycle returns
  // them; eval reads gen at popped slot is not possible in time, so the
  // generation for reuse is read in StRead via the fifo data path below.
  logic [GenBits-1:0] gen_hold_q;
  logic [IW-1:0]      sdi_hold_q;
  logic               phase_q;   // first cycle after capture

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      mode_q <= mode_i;
      idx_q  <= handle_index_i;
      gen_q  <= handle_generation_i;
      pos_q  <= {pos_z_i, pos_y_i, pos_x_i};
    end
    if (phase_q) begin
      gen_hold_q <= gen_rd;
      sdi_hold_q <= sdi_rd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) phase_q <= 1'b0;
    else phase_q <= ctl_i.capture;
  end

  // Eval: handle check and allocation choice. gen_rd now holds the
  // generation of the slot at the fifo head (read issued in StRead).
  logic          hit;
  logic [GenBits-1:0] bump;
  always_comb begin
    hit  = ({1'b0, idx_q} < opened_q) && active_q[idx_q] && (gen_hold_q == gen_q);
    bump = gen_rd + GenBits'(1);
    if (bump == '0) bump = GenBits'(1);
  end

  assign pay_ra   = ctl_i.eval ? ((mode_q == MODE_LOOKUP) ? sdi_hold_q
                                                           : IW'(dcount_q - CW'(1)))
                               : sdi_rd;
  assign owner_ra = IW'(dcount_q - CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0; got_q <= 1'b0; reuse_q <= 1'b0; move_q <= 1'b0;
      st_q <= STATUS_BAD; slot_q <= '0; hole_q <= '0; last_q <= '0;
      newgen_q <= '0;
    end else if (ctl_i.eval) begin
      ok_q    <= hit;
      hole_q  <= sdi_hold_q;
      last_q  <= IW'(dcount_q - CW'(1));
      reuse_q <= (fcount_q != '0) && (dcount_q < Full);
      got_q   <= ((fcount_q != '0) || (opened_q < Full)) && (dcount_q < Full);
      slot_q  <= (fcount_q != '0) ? fifo_rd : IW'(opened_q);
      newgen_q <= (fcount_q != '0) ? bump : GenBits'(1);
      move_q  <= (mode_q == MODE_DELETE) && hit &&
                 (sdi_hold_q != IW'(dcount_q - CW'(1)));
      priority if (mode_q == MODE_ADD)
        st_q <= (((fcount_q != '0) || (opened_q < Full)) && (dcount_q < Full))
                ? STATUS_OK : STATUS_FULL;
      else if (mode_q == MODE_LOOKUP || mode_q == MODE_DELETE)
        st_q <= hit ? STATUS_OK : STATUS_BAD;
      else
        st_q <= STATUS_BAD;
    end
  end

  assign sts_o.need_move = move_q;

  logic do_add, do_del;
  assign do_add = ctl_i.commit && (mode_q == MODE_ADD) && got_q;
  assign do_del = ctl_i.commit && (mode_q == MODE_DELETE) && ok_q;

  // Move cycle: mover_q and mpay_q hold the last entry (read in eval, latched in commit).
  logic [IW-1:0] mover_q;
  logic [PW-1:0] mpay_q;
  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      mover_q <= owner_rd;
      mpay_q  <= pay_rd;
    end
  end

  // Tail of the free ring, wrapped at the slot count.
  logic [CW-1:0] fifo_sum;

  always_comb begin
    gen_we = do_add; gen_wa = slot_q; gen_wd = newgen_q;
    sdi_we = do_add || ctl_i.move;
    sdi_wa = ctl_i.move ? mover_q : slot_q;
    sdi_wd = ctl_i.move ? hole_q : IW'(dcount_q);
    fifo_we = do_del && (fcount_q < Full);
    fifo_sum = {1'b0, fhead_q} + fcount_q;
    fifo_wa = (fifo_sum >= Full) ? IW'(fifo_sum - Full) : IW'(fifo_sum);
    owner_we = do_add || ctl_i.move;
    owner_wa = ctl_i.move ? hole_q : IW'(dcount_q);
    owner_wd = ctl_i.move ? mover_q : slot_q;
    pay_we = do_add || ctl_i.move;
    pay_wa = ctl_i.move ? hole_q : IW'(dcount_q);
    pay_wd = ctl_i.move ? mpay_q : pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0; opened_q <= '0; fcount_q <= '0; dcount_q <= '0;
      fhead_q <= '0;
    end else begin
      if (do_add) begin
        active_q[slot_q] <= 1'b1;
        dcount_q <= dcount_q + CW'(1);
        if (reuse_q) begin
          fhead_q  <= (fhead_q == IW'(SlotCount - 1)) ? '0 : fhead_q + IW'(1);
          fcount_q <= fcount_q - CW'(1);
        end else begin
          opened_q <= opened_q + CW'(1);
        end
      end
      if (do_del) begin
        active_q[idx_q] <= 1'b0;
        if (fcount_q < Full) fcount_q <= fcount_q + CW'(1);
        if (dcount_q != '0) dcount_q <= dcount_q - CW'(1);
      end
    end
  end

  // Lookup payload: read in eval at the slot's dense index; data arrives
  // in commit, which is also the respond cycle for a lookup.
  logic [PW-1:0] mpay_sel;
  assign mpay_sel = pay_rd;

  // Result word, registered when respond is high.
  logic lk;
  assign lk = (mode_q == MODE_LOOKUP) && ok_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else done_o <= ctl_i.respond;
  end
  always_ff @(posedge clk_i) begin
    if (ctl_i.respond) begin
      status_o <= st_q;
      result_index_o      <= do_add || (mode_q == MODE_ADD && got_q) ? slot_q : idx_q;
      result_generation_o <= (mode_q == MODE_ADD && got_q) ? newgen_q : gen_q;
      dense_position_o    <= (mode_q == MODE_ADD && got_q) ? last_q + IW'(1)
                           : lk ? hole_q : '0;
      out_x_o <= lk ? mpay_sel[31:0]  : '0;
      out_y_o <= lk ? mpay_sel[63:32] : '0;
      out_z_o <= lk ? mpay_sel[95:64] : '0;
    end
  end

  a_add_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_add |=> dcount_q == $past(dcount_q) + CW'(1))
    else $error("dense count did not grow");
  a_dense_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcount_q <= Full)
    else $error("dense count overflow");
  a_opened_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    opened_q <= Full && fcount_q <= Full)
    else $error("counter overflow");

endmodule

FILE: sv/generational_handle_table.sv
// Generational handle table. Raise start while busy is low to issue one
// command word (add, look up or delete); it is taken at the rising edge where
// start is high and busy is low. Each command produces exactly one result
// word, shown for a single cycle with done_o high; the receiver cannot stall
// it, so capture it on that cycle. done_o rises and busy drops in the same
// cycle, so the next command can be taken at the edge that ends it; a new
// command is not taken until the last one is through. A delete that moves
// the last dense entry into the hole adds a move step before the result.
// The sequence follows the chain of registered-read RAM accesses: slot data
// first, then the dense store, then the writes. No clearing pass is needed
// after reset.
module generational_handle_table
  import ght_pkg::*;
#(
  parameter int SLOT_COUNT = 64,
  parameter int GEN_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  output logic                          done_o,
  input  logic [1:0]                    mode_i,
  input  logic [$clog2(SLOT_COUNT)-1:0] handle_index_i,
  input  logic [GEN_BITS-1:0]           handle_generation_i,
  input  logic [31:0]                   pos_x_i,
  input  logic [31:0]                   pos_y_i,
  input  logic [31:0]                   pos_z_i,
  output logic [1:0]                    status_o,
  output logic [$clog2(SLOT_COUNT)-1:0] result_index_o,
  output logic [GEN_BITS-1:0]           result_generation_o,
  output logic [$clog2(SLOT_COUNT)-1:0] dense_position_o,
  output logic [31:0]                   out_x_o,
  output logic [31:0]                   out_y_o,
  output logic [31:0]                   out_z_o
);

  ctl_t ctl;
  sts_t sts;

  // Sequence the command through read, evaluate, commit and move.
  ght_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .sts_i(sts), .ctl_o(ctl), .busy_o(busy)
  );

  // Hold the slot, free-list and dense stores.
  ght_dp #(.SlotCount(SLOT_COUNT), .GenBits(GEN_BITS)) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts),
    .mode_i, .handle_index_i, .handle_generation_i,
    .pos_x_i, .pos_y_i, .pos_z_i,
    .done_o, .status_o, .result_index_o, .result_generation_o,
    .dense_position_o, .out_x_o, .out_y_o, .out_z_o
  );

endmodule

FILE: tb/sv/ght_checker.sv
`timescale 1ns / 1ps

module ght_checker
  import ght_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic        done_o,
  input  logic [1:0]  mode_i,
  input  logic [5:0]  handle_index_i,
  input  logic [15:0] handle_generation_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [1:0]  status_o,
  input  logic [5:0]  result_index_o,
  input  logic [15:0] result_generation_o,
  input  logic [5:0]  dense_position_o,
  input  logic [31:0] out_x_o,
  input  logic [31:0] out_y_o,
  input  logic [31:0] out_z_o,
  output int          pending_o,
  output int          fail_count_o
);

  localparam int SLOTS = 64;

  typedef struct {
    status_e     status;
    logic [5:0]  index;
    logic [15:0] generation;
    logic [5:0]  dpos;
    logic [31:0] x, y, z;
  } table_word_t;

  table_word_t expected_words[$];

  logic [15:0] slot_gen   [SLOTS];
  bit          slot_live  [SLOTS];
  logic [5:0]  slot_dpos  [SLOTS];
  logic [5:0]  free_ring  [SLOTS];
  logic [5:0]  dense_slot [SLOTS];
  logic [31:0] dense_x [SLOTS], dense_y [SLOTS], dense_z [SLOTS];
  int opened, ring_head, ring_count, dense_used;

  initial begin
    fail_count_o = 0;
    opened = 0;
    ring_head = 0;
    ring_count = 0;
    dense_used = 0;
    foreach (slot_live[i]) slot_live[i] = 0;
  end

  assign pending_o = expected_words.size();

  function automatic bit handle_valid(logic [5:0] idx, logic [15:0] gen);
    return (idx < opened) && slot_live[idx] && (slot_gen[idx] == gen);
  endfunction

  // Apply one command to the shadow table and return the word it yields.
  function automatic table_word_t table_apply(mode_e mode, logic [5:0] idx,
                                              logic [15:0] gen, logic [31:0] x,
                                              logic [31:0] y, logic [31:0] z);
    table_word_t w;
    int slot, p, last, mover;
    bit got;
    logic [15:0] g;
    w = '{STATUS_BAD, idx, gen, '0, '0, '0, '0};
    got = 0;
    slot = 0;
    g = '0;
    case (mode)
      MODE_ADD: begin
        if (ring_count > 0 && dense_used < SLOTS) begin
          slot = free_ring[ring_head];
          ring_head = (ring_head + 1) % SLOTS;
          ring_count--;
          g = slot_gen[slot] + 16'd1;
          if (g == 0) g = 16'd1;  // generation zero is never handed out
          got = 1;
        end else if (opened < SLOTS && dense_used < SLOTS) begin
          slot = opened;
          opened++;
          g = 16'd1;
          got = 1;
        end
        if (got) begin
          p = dense_used;
          slot_gen[slot] = g;
          slot_live[slot] = 1;
          slot_dpos[slot] = 6'(p);
          dense_slot[p] = 6'(slot);
          dense_x[p] = x;
          dense_y[p] = y;
          dense_z[p] = z;
          dense_used++;
          w.status = STATUS_OK;
          w.index = 6'(slot);
          w.generation = g;
          w.dpos = 6'(p);
        end else begin
          w.status = STATUS_FULL;
        end
      end
      MODE_LOOKUP: begin
        if (handle_valid(idx, gen)) begin
          p = slot_dpos[idx];
          w.status = STATUS_OK;
          w.dpos = 6'(p);
          w.x = dense_x[p];
          w.y = dense_y[p];
          w.z = dense_z[p];
        end
      end
      MODE_DELETE: begin
        if (handle_valid(idx, gen)) begin
          p = slot_dpos[idx];
          free_ring[(ring_head + ring_count) % SLOTS] = idx;
          ring_count++;
          slot_live[idx] = 0;
          last = dense_used - 1;
          // Fill the hole with the last dense entry.
          if (p != last) begin
            mover = dense_slot[last];
            dense_slot[p] = 6'(mover);
            dense_x[p] = dense_x[last];
            dense_y[p] = dense_y[last];
            dense_z[p] = dense_z[last];
            slot_dpos[mover] = 6'(p);
          end
          dense_used--;
          w.status = STATUS_OK;
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    table_word_t w;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          fail_count_o++;
        end else begin
          w = expected_words[0];
          expected_words.delete(0);
          compare_field("status", w.status, status_o);
          compare_field("result_index", w.index, result_index_o);
          compare_field("result_generation", w.generation, result_generation_o);
          compare_field("dense_position", w.dpos, dense_position_o);
          compare_field("out_x", w.x, out_x_o);
          compare_field("out_y", w.y, out_y_o);
          compare_field("out_z", w.z, out_z_o);
        end
      end
      if (start && !busy)
        expected_words.push_back(table_apply(mode_e'(mode_i), handle_index_i,
                                             handle_generation_i, pos_x_i, pos_y_i,
                                             pos_z_i));
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ght_pkg::*;

  localparam longint CYCLE_LIMIT = 100_000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic        done_o;
  logic [1:0]  mode_i = MODE_LOOKUP;
  logic [5:0]  handle_index_i = '0;
  logic [15:0] handle_generation_i = '0;
  logic [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [1:0]  status_o;
  logic [5:0]  result_index_o, dense_position_o;
  logic [15:0] result_generation_o;
  logic [31:0] out_x_o, out_y_o, out_z_o;
  int          pending, fail_count;
  longint      cycles = 0;

  // Handles returned by successful adds; used to build legal lookups/deletes.
  typedef struct {
    logic [5:0]  index;
    logic [15:0] generation;
  } handle_t;
  handle_t live_handles[$];
  mode_e   sent_modes[$];
  int      idle_pct = 0;

  always #2 clk_i = ~clk_i;

  generational_handle_table u_dut (
    .clk_i, .rst_ni, .start, .busy, .done_o, .mode_i, .handle_index_i,
    .handle_generation_i, .pos_x_i, .pos_y_i, .pos_z_i, .status_o,
    .result_index_o, .result_generation_o, .dense_position_o,
    .out_x_o, .out_y_o, .out_z_o
  );

  ght_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .done_o, .mode_i, .handle_index_i,
    .handle_generation_i, .pos_x_i, .pos_y_i, .pos_z_i, .status_o,
    .result_index_o, .result_generation_o, .dense_position_o,
    .out_x_o, .out_y_o, .out_z_o, .pending_o(pending), .fail_count_o(fail_count)
  );

  // Watchdog: end the run if it hangs.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Harvest fresh handles from add results.
  always @(posedge clk_i) begin
    mode_e m;
    if (rst_ni && done_o && sent_modes.size() > 0) begin
      m = sent_modes[0];
      sent_modes.delete(0);
      if (m == MODE_ADD && status_o == STATUS_OK)
        live_handles.push_back('{result_index_o, result_generation_o});
    end
  end

  // Issue one command word; hold start until the block takes it.
  task automatic issue(mode_e m, logic [5:0] idx, logic [15:0] gen,
                       logic [31:0] x = $urandom, logic [31:0] y = $urandom,
                       logic [31:0] z = $urandom);
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start = 0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    mode_i = m;
    handle_index_i = idx;
    handle_generation_i = gen;
    pos_x_i = x;
    pos_y_i = y;
    pos_z_i = z;
    start = 1;
    do @(posedge clk_i); while (busy);
    sent_modes.push_back(m);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Random mix: mostly legal handles, some stale or corrupted ones.
  task automatic random_burst(int count, int add_pct);
    handle_t h;
    int k, r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < add_pct) begin
        issue(MODE_ADD, 6'($urandom), 16'($urandom));
      end else if (r > 96 || live_handles.size() == 0) begin
        issue(mode_e'($urandom_range(3)), 6'($urandom), 16'($urandom));
      end else begin
        k = $urandom_range(live_handles.size() - 1);
        h = live_handles[k];
        if ($urandom_range(9) == 0) h.generation ^= 16'(1 << $urandom_range(15));
        if ($urandom_range(1)) begin
          issue(MODE_LOOKUP, h.index, h.generation);
        end else begin
          issue(MODE_DELETE, h.index, h.generation);
          live_handles.delete(k);
        end
      end
    end
  endtask

  initial begin
    logic [15:0] g;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed: empty table, unknown mode, extreme payloads.
    issue(MODE_LOOKUP, 6'd0, 16'd1);
    issue(MODE_DELETE, 6'd63, 16'hFFFF);
    issue(MODE_RSVD, 6'd63, 16'hFFFF, '1, '1, '1);
    issue(MODE_ADD, 6'd63, 16'hFFFF, '1, '1, '1);
    issue(MODE_LOOKUP, 6'd0, 16'd1);
    issue(MODE_LOOKUP, 6'd0, 16'd2);
    issue(MODE_ADD, 6'd0, 16'd0, '0, '0, '0);
    issue(MODE_ADD, 6'd0, 16'd0, 32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000);
    // Delete from the middle: the last entry moves into the hole.
    issue(MODE_DELETE, 6'd0, 16'd1);
    issue(MODE_LOOKUP, 6'd2, 16'd1);
    issue(MODE_LOOKUP, 6'd0, 16'd1);
    issue(MODE_DELETE, 6'd0, 16'd1);
    issue(MODE_LOOKUP, 6'd5, 16'd1);
    // Delete of the last dense entry: just shrink.
    issue(MODE_DELETE, 6'd1, 16'd1);
    issue(MODE_DELETE, 6'd2, 16'd1);
    issue(MODE_LOOKUP, 6'd63, 16'hFFFF);
    drain();

    // Recycle slot 0 a few times; each reuse bumps its generation.
    // The free ring holds 0, 1, 2 in that order, so re-open each; with the
    // ring empty again, every delete of slot 0 hands it straight back.
    issue(MODE_ADD, '0, '0);
    issue(MODE_ADD, '0, '0);
    issue(MODE_ADD, '0, '0);
    g = 16'd2;
    for (int n = 0; n < 10; n++) begin
      issue(MODE_DELETE, 6'd0, g);
      issue(MODE_ADD, '0, '0);
      g = (g == 16'hFFFF) ? 16'd1 : g + 16'd1;
    end
    issue(MODE_DELETE, 6'd1, 16'd2);
    issue(MODE_DELETE, 6'd2, 16'd2);
    issue(MODE_LOOKUP, 6'd0, g);
    issue(MODE_LOOKUP, 6'd0, 16'd0);
    drain();
    live_handles.delete();
    live_handles.push_back('{6'd0, g});

    // Sender idles sometimes, then often, then never; add-heavy first to fill up.
    idle_pct = 24;
    random_burst(150, 75);
    random_burst(40, 95);
    drain();  // pause until every word has come back
    idle_pct = 80;
    random_burst(150, 30);
    idle_pct = 0;
    random_burst(100, 60);
    random_burst(80, 25);
    drain();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/ght_pkg.sv
sv/ght_ram.sv
sv/ght_ctrl.sv
sv/ght_dp.sv
sv/generational_handle_table.sv
tb/sv/ght_checker.sv
tb/sv/tb_top.sv
